FILE: src/irtx_pkg.sv
package irtx_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_BURST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT         = 2'd2;

  localparam logic [LEN_W-1:0] LEADER_BURST_RST = 16'd9000;
  localparam logic [LEN_W-1:0] LEADER_GAP_RST   = 16'd4500;
  localparam logic [LEN_W-1:0] SLOT_RST         = 16'd562;

  // item kinds on in_tuser
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_LEAD_BURST = 7'b0000010,
    PH_LEAD_GAP   = 7'b0000100,
    PH_BIT_BURST  = 7'b0001000,
    PH_BIT_GAP    = 7'b0010000,
    PH_STOP_BURST = 7'b0100000,
    PH_STOP_GAP   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] leader_burst;
    logic [LEN_W-1:0] leader_gap;
    logic [LEN_W-1:0] slot;
  } seg_len_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] frame_data;
    logic [BYTE_W-1:0] frame_address;
  } tx_item_t;

  typedef struct packed {
    logic frame_done;
    logic busy_res;
    logic carrier_on;
  } tx_result_t;

  // a programmed length of zero runs as one tick
  function automatic logic [LEN_W-1:0] at_least_one(input logic [LEN_W-1:0] v);
    at_least_one = (v == '0) ? LEN_W'(1) : v;
  endfunction

endpackage

FILE: src/irtx_cfg_regs.sv
module irtx_cfg_regs
  import irtx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [LEN_W-1:0]     wr_data,
  output seg_len_t             seg_len
);

  seg_len_t seg_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r.leader_burst <= LEADER_BURST_RST;
      seg_len_r.leader_gap   <= LEADER_GAP_RST;
      seg_len_r.slot         <= SLOT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LEADER_BURST: seg_len_r.leader_burst <= wr_data;
        REG_LEADER_GAP:   seg_len_r.leader_gap   <= wr_data;
        REG_SLOT:         seg_len_r.slot         <= wr_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  assign seg_len = seg_len_r;

endmodule

FILE: src/irtx_frame_fsm.sv
module irtx_frame_fsm
  import irtx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  tx_item_t   item,
  input  seg_len_t   seg_len,
  output tx_result_t result
);

  phase_t            phase_r, phase_nxt;
  logic [1:0]        byte_sel_r, byte_sel_nxt;
  logic [2:0]        bit_pos_r, bit_pos_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [BYTE_W-1:0] addr_r, addr_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              carrier_r, carrier_nxt;
  logic              done;

  logic [BYTE_W-1:0] cur_byte;
  logic              cur_bit;
  logic [LEN_W-1:0]  rem_dec;
  logic [LEN_W-1:0]  slot_len;

  assign cur_byte = (byte_sel_r[1] ? data_r : addr_r) ^ {BYTE_W{byte_sel_r[0]}};
  assign cur_bit  = cur_byte[3'd7 - bit_pos_r];
  assign rem_dec  = (rem_r == '0) ? '0 : rem_r - LEN_W'(1);
  assign slot_len = at_least_one(seg_len.slot);

  always_comb begin
    phase_nxt    = phase_r;
    byte_sel_nxt = byte_sel_r;
    bit_pos_nxt  = bit_pos_r;
    slot_nxt     = slot_r;
    rem_nxt      = rem_r;
    addr_nxt     = addr_r;
    data_nxt     = data_r;
    carrier_nxt  = carrier_r;
    done         = 1'b0;

    if (item.kind == KIND_START) begin
      addr_nxt     = item.frame_address;
      data_nxt     = item.frame_data;
      byte_sel_nxt = '0;
      bit_pos_nxt  = '0;
      slot_nxt     = '0;
      phase_nxt    = PH_LEAD_BURST;
      rem_nxt      = at_least_one(seg_len.leader_burst);
      carrier_nxt  = 1'b1;
    end else if (phase_r == PH_IDLE) begin
      phase_nxt   = PH_IDLE;
      rem_nxt     = '0;
      carrier_nxt = 1'b0;
    end else begin
      rem_nxt = rem_dec;
      if (rem_dec == '0) begin
        // segment over: load the next one
        unique case (phase_r)
          PH_LEAD_BURST: begin
            phase_nxt   = PH_LEAD_GAP;
            rem_nxt     = at_least_one(seg_len.leader_gap);
            carrier_nxt = 1'b0;
          end
          PH_LEAD_GAP: begin
            byte_sel_nxt = '0;
            bit_pos_nxt  = '0;
            phase_nxt    = PH_BIT_BURST;
            rem_nxt      = slot_len;
            carrier_nxt  = 1'b1;
          end
          PH_BIT_BURST: begin
            slot_nxt    = '0;
            phase_nxt   = PH_BIT_GAP;
            rem_nxt     = slot_len;
            carrier_nxt = 1'b0;
          end
          PH_BIT_GAP: begin
            rem_nxt = slot_len;
            if (cur_bit && slot_r < 2'd2) begin
              // a one bit holds the gap for three slots
              slot_nxt    = slot_r + 2'd1;
              phase_nxt   = PH_BIT_GAP;
              carrier_nxt = 1'b0;
            end else begin
              slot_nxt    = '0;
              carrier_nxt = 1'b1;
              phase_nxt   = PH_BIT_BURST;
              bit_pos_nxt = bit_pos_r + 3'd1;
              if (bit_pos_r == 3'd7) begin
                if (byte_sel_r == 2'd3) begin
                  byte_sel_nxt = '0;
                  phase_nxt    = PH_STOP_BURST;
                end else begin
                  byte_sel_nxt = byte_sel_r + 2'd1;
                end
              end
            end
          end
          PH_STOP_BURST: begin
            phase_nxt   = PH_STOP_GAP;
            rem_nxt     = slot_len;
            carrier_nxt = 1'b0;
          end
          default: begin
            phase_nxt   = PH_IDLE;
            rem_nxt     = '0;
            carrier_nxt = 1'b0;
            done        = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      byte_sel_r <= '0;
      bit_pos_r  <= '0;
      slot_r     <= '0;
      rem_r      <= '0;
      addr_r     <= '0;
      data_r     <= '0;
      carrier_r  <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      byte_sel_r <= byte_sel_nxt;
      bit_pos_r  <= bit_pos_nxt;
      slot_r     <= slot_nxt;
      rem_r      <= rem_nxt;
      addr_r     <= addr_nxt;
      data_r     <= data_nxt;
      carrier_r  <= carrier_nxt;
    end
  end

  assign result.carrier_on = carrier_nxt;
  assign result.busy_res   = (phase_nxt != PH_IDLE);
  assign result.frame_done = done;

endmodule

FILE: src/ir_pulse_distance_frame_tx.sv
// Pulse-distance IR frame transmitter: a start item (in_tuser high) loads an address and a
// data byte and begins a frame; each tick item (in_tuser low) advances it by one microsecond.
// Every item yields exactly one result carrying the carrier gate and busy flag, with out_tlast
// marking the tick that ends the stop gap. The block takes one item per clock while out_tready
// allows it: an input register feeds the frame sequencer, whose result lands in an output
// register. Configuration writes are accepted every cycle and should be issued while no item
// is in flight.
module ir_pulse_distance_frame_tx
  import irtx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [7:0] frame_address, [15:8] frame_data
  input  logic                 in_tuser,   // kind
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [0] carrier_on, [1] busy_res, [7:2] zero
  output logic                 out_tlast,  // frame_done
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  tx_item_t   item_r;
  logic       item_vld_r;
  tx_result_t res_r;
  logic       res_vld_r;
  tx_result_t res_nxt;
  seg_len_t   seg_len;
  logic       advance;
  logic       step;

  assign cfg_ready = 1'b1;
  assign advance   = !res_vld_r || out_tready;
  assign step      = item_vld_r && advance;
  assign in_tready = !item_vld_r || advance;

  irtx_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .seg_len  (seg_len)
  );

  irtx_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .item    (item_r),
    .seg_len (seg_len),
    .result  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind          <= in_tuser;
      item_r.frame_address <= in_tdata[7:0];
      item_r.frame_data    <= in_tdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {6'd0, res_r.busy_res, res_r.carrier_on};
  assign out_tlast  = res_r.frame_done;

endmodule

FILE: test/ir_pulse_distance_frame_tx_test.sv
module ir_pulse_distance_frame_tx_test;
  import irtx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;

  class frame_tracker;
    logic [LEN_W-1:0]  burst_len, gap_len, slot_len;
    phase_t            ph;
    logic [1:0]        byte_sel;
    logic [2:0]        bit_pos;
    logic [1:0]        slot_cnt;
    logic [LEN_W-1:0]  ticks_left;
    logic [BYTE_W-1:0] addr_q, data_q;
    logic              level;
    tx_result_t        pending_results[$];
    int                errors, checked, items, starts, frames_ended;

    function new();
      burst_len = LEADER_BURST_RST;
      gap_len = LEADER_GAP_RST;
      slot_len = SLOT_RST;
      ph = PH_IDLE;
      byte_sel = '0;
      bit_pos = '0;
      slot_cnt = '0;
      ticks_left = '0;
      addr_q = '0;
      data_q = '0;
      level = 1'b0;
      errors = 0;
      checked = 0;
      items = 0;
      starts = 0;
      frames_ended = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] v);
      case (idx)
        REG_LEADER_BURST: burst_len = v;
        REG_LEADER_GAP:   gap_len = v;
        REG_SLOT:         slot_len = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    // a zero length still runs for one tick
    function void load(phase_t p, logic [LEN_W-1:0] len, logic lvl);
      ph = p;
      ticks_left = (len == '0) ? LEN_W'(1) : len;
      level = lvl;
    endfunction

    function logic bit_now();
      logic [BYTE_W-1:0] b;
      b = byte_sel[1] ? data_q : addr_q;
      if (byte_sel[0]) b = ~b;
      return b[3'd7 - bit_pos];
    endfunction

    // move to the next segment; returns 1 when the stop gap has ended
    function logic segment_over();
      case (ph)
        PH_LEAD_BURST: load(PH_LEAD_GAP, gap_len, 1'b0);
        PH_LEAD_GAP: begin
          byte_sel = '0;
          bit_pos = '0;
          load(PH_BIT_BURST, slot_len, 1'b1);
        end
        PH_BIT_BURST: begin
          slot_cnt = '0;
          load(PH_BIT_GAP, slot_len, 1'b0);
        end
        PH_BIT_GAP: begin
          if (bit_now() && slot_cnt < 2'd2) begin
            slot_cnt++;
            load(PH_BIT_GAP, slot_len, 1'b0);
          end else begin
            slot_cnt = '0;
            if (bit_pos != 3'd7) begin
              bit_pos++;
              load(PH_BIT_BURST, slot_len, 1'b1);
            end else begin
              bit_pos = '0;
              if (byte_sel == 2'd3) begin
                byte_sel = '0;
                load(PH_STOP_BURST, slot_len, 1'b1);
              end else begin
                byte_sel++;
                load(PH_BIT_BURST, slot_len, 1'b1);
              end
            end
          end
        end
        PH_STOP_BURST: load(PH_STOP_GAP, slot_len, 1'b0);
        default: begin
          ph = PH_IDLE;
          ticks_left = '0;
          level = 1'b0;
          return 1'b1;
        end
      endcase
      return 1'b0;
    endfunction

    function void note_item(logic kind, logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] d);
      tx_result_t r;
      r = '0;
      items++;
      if (kind == KIND_START) begin
        addr_q = a;
        data_q = d;
        byte_sel = '0;
        bit_pos = '0;
        slot_cnt = '0;
        load(PH_LEAD_BURST, burst_len, 1'b1);
        starts++;
      end else if (ph != PH_IDLE) begin
        if (ticks_left != '0) ticks_left--;
        if (ticks_left == '0) r.frame_done = segment_over();
      end else begin
        ticks_left = '0;
        level = 1'b0;
      end
      r.carrier_on = level;
      r.busy_res = (ph != PH_IDLE);
      if (r.frame_done) frames_ended++;
      pending_results.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH: %0s", what);
      errors++;
    endtask

    task check_result(logic [7:0] td, logic tl);
      tx_result_t w;
      if (pending_results.size() == 0) begin
        report($sformatf("result with none pending: tdata=%h tlast=%b", td, tl));
        return;
      end
      w = pending_results.pop_front();
      checked++;
      if (td[0] !== w.carrier_on)
        report($sformatf("result %0d carrier_on=%b, want %b", checked, td[0], w.carrier_on));
      if (td[1] !== w.busy_res)
        report($sformatf("result %0d busy_res=%b, want %b", checked, td[1], w.busy_res));
      if (tl !== w.frame_done)
        report($sformatf("result %0d frame_done=%b, want %b", checked, tl, w.frame_done));
      if (td[7:2] !== 6'd0)
        report($sformatf("result %0d pad bits=%b, want zero", checked, td[7:2]));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;

  frame_tracker sb;
  int gap_pct;
  int stall_pct;
  int cycles;

  ir_pulse_distance_frame_tx uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] addr, input logic [7:0] data);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {data, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, addr, data);
    @(negedge clk);
  endtask

  // hold until every result is back, then give the pipeline time to empty
  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_lengths(input logic [LEN_W-1:0] b, input logic [LEN_W-1:0] g,
                             input logic [LEN_W-1:0] s);
    drain();
    cfg_write(REG_LEADER_BURST, b);
    cfg_write(REG_LEADER_GAP, g);
    cfg_write(REG_SLOT, s);
    cfg_valid <= 1'b0;
  endtask

  // mode: 0 steady, 1 sender gaps, 2 receiver stalls, 3 light gaps on both sides
  task automatic run_phase(input int n, input int mode, input int restart_per_mille);
    logic        kind;
    logic [15:0] rnd;
    case (mode)
      1:       begin gap_pct = 79; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 79; end
      3:       begin gap_pct = 13; stall_pct = 13; end
      default: begin gap_pct = 0;  stall_pct = 0;  end
    endcase
    for (int k = 0; k < n; k++) begin
      rnd = 16'($urandom);
      if (k == 0)
        kind = KIND_START;
      else if (sb.busy())
        kind = ($urandom_range(999) < restart_per_mille) ? KIND_START : KIND_TICK;
      else
        kind = ($urandom_range(99) < 70) ? KIND_START : KIND_TICK;
      send_item(kind, rnd[7:0], rnd[15:8]);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_TICK;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LEADER_BURST;
    cfg_data = '0;
    gap_pct = 0;
    stall_pct = 0;
    cycles = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle ticks, a frame start, a restart mid-frame, all with reset lengths
    send_item(KIND_TICK, 8'hff, 8'hff);
    send_item(KIND_TICK, 8'h00, 8'h00);
    send_item(KIND_START, 8'hff, 8'h00);
    repeat (4) send_item(KIND_TICK, 8'($urandom), 8'($urandom));
    send_item(KIND_START, 8'h00, 8'hff);
    repeat (3) send_item(KIND_TICK, 8'($urandom), 8'($urandom));
    send_item(KIND_START, 8'ha5, 8'h5a);
    repeat (3) send_item(KIND_TICK, 8'($urandom), 8'($urandom));
    in_tvalid <= 1'b0;

    // lengths change while the last frame is still running
    set_lengths('0, '0, '0);
    run_phase(250, 0, 5);
    set_lengths(LEN_W'($urandom_range(12)), LEN_W'($urandom_range(8)),
                LEN_W'($urandom_range(1)));
    run_phase(250, 1, 5);
    set_lengths(16'hffff, 16'd1, 16'd1);
    run_phase(40, 2, 50);
    set_lengths(16'd1, 16'hffff, 16'd1);
    run_phase(40, 3, 50);
    set_lengths('0, '0, 16'hffff);
    run_phase(40, 0, 50);
    set_lengths(LEN_W'($urandom_range(12)), LEN_W'($urandom_range(8)),
                LEN_W'($urandom_range(1)));
    run_phase(250, 1, 5);
    set_lengths(LEN_W'($urandom_range(12)), LEN_W'($urandom_range(8)),
                LEN_W'($urandom_range(1)));
    run_phase(250, 2, 5);
    set_lengths(LEN_W'($urandom_range(6)), LEN_W'($urandom_range(6)),
                LEN_W'($urandom_range(4, 2)));
    run_phase(250, 3, 5);

    drain();
    repeat (8) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Sent %0d items (%0d frame starts), checked %0d results, %0d frames ran to the end",
             sb.items, sb.starts, sb.checked, sb.frames_ended);
    $display("Lengths swept from zero to full scale under steady, gapped and stalled flow");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
